// ===== design/wclm_pkg.sv =====
// Shared types, constants and mask helpers for the word clock LED mask block.
package wclm_pkg;

  // Panel geometry
  localparam int unsigned NumLeds   = 116;
  localparam int unsigned PanelBits = 116;
  localparam int unsigned LowBits   = 64;
  localparam int unsigned HighBits  = PanelBits - LowBits;
  localparam int unsigned LedIdxW   = 7;

  // Field widths
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StepW   = 4;
  localparam int unsigned RestW   = 3;
  localparam int unsigned ShownW  = 6;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgSouthernDialect = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCompactDots     = 2'd1;

  // Five-minute step codes (minute / 5)
  localparam logic [StepW-1:0] StepOclock     = 4'd0;
  localparam logic [StepW-1:0] StepFivePast   = 4'd1;
  localparam logic [StepW-1:0] StepTenPast    = 4'd2;
  localparam logic [StepW-1:0] StepQuarter    = 4'd3;
  localparam logic [StepW-1:0] StepTwentyPast = 4'd4;
  localparam logic [StepW-1:0] StepFiveToHalf = 4'd5;
  localparam logic [StepW-1:0] StepHalf       = 4'd6;
  localparam logic [StepW-1:0] StepFiveAfHalf = 4'd7;
  localparam logic [StepW-1:0] StepTwentyTo   = 4'd8;
  localparam logic [StepW-1:0] StepQuarterTo  = 4'd9;
  localparam logic [StepW-1:0] StepTenTo      = 4'd10;
  localparam logic [StepW-1:0] StepFiveTo     = 4'd11;

  // Reciprocal of five for a 6-bit minute: (m * 13) >> 6 == m / 5 for m < 64
  localparam int unsigned Div5Mul   = 13;
  localparam int unsigned Div5Shift = 6;
  localparam int unsigned Div5ProdW = MinuteW + 4;

  localparam int unsigned HalfDay = 12;

  typedef logic [PanelBits-1:0] panel_t;

  typedef struct packed {
    logic southern_dialect;
    logic compact_dot_layout;
  } wclm_cfg_t;

  typedef struct packed {
    logic [LedIdxW-1:0] lo;
    logic [LedIdxW-1:0] hi;
  } span_t;

  // Lights LEDs lo..hi inclusive within the panel
  function automatic panel_t span_mask(input logic [LedIdxW-1:0] lo,
                                       input logic [LedIdxW-1:0] hi);
    panel_t m;
    m = '0;
    for (int p = 0; p < PanelBits; p++) begin
      if ((LedIdxW'(p) >= lo) && (LedIdxW'(p) <= hi)) begin
        m[p] = 1'b1;
      end
    end
    return m;
  endfunction

  // Hour word for a displayed hour 0..12 (0 and 12 are ZWOELF)
  function automatic span_t hour_word(input logic [3:0] h);
    span_t s;
    case (h)
      4'd0:    s = '{lo: 7'd49,  hi: 7'd53};
      4'd1:    s = '{lo: 7'd60,  hi: 7'd63};
      4'd2:    s = '{lo: 7'd62,  hi: 7'd65};
      4'd3:    s = '{lo: 7'd67,  hi: 7'd70};
      4'd4:    s = '{lo: 7'd77,  hi: 7'd80};
      4'd5:    s = '{lo: 7'd73,  hi: 7'd76};
      4'd6:    s = '{lo: 7'd104, hi: 7'd108};
      4'd7:    s = '{lo: 7'd55,  hi: 7'd60};
      4'd8:    s = '{lo: 7'd89,  hi: 7'd92};
      4'd9:    s = '{lo: 7'd81,  hi: 7'd84};
      4'd10:   s = '{lo: 7'd93,  hi: 7'd96};
      4'd11:   s = '{lo: 7'd85,  hi: 7'd87};
      default: s = '{lo: 7'd49,  hi: 7'd53};
    endcase
    return s;
  endfunction

endpackage

// ===== design/word_clock_led_mask.sv =====
// Top level of the word clock LED mask block: input register, decode, result register.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-----------------------------------
//   input    | in_valid_i / in_stall_o      | hour_of_day_i, minute_of_hour_i
//   result   | out_valid_o / out_stall_i    | leds_low_o, leds_high_o
//   config   | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while the result is not stalled; a
// result reaches the outputs through the input register, then decode into
// the result register.
// Reset clears the valid flags and both configuration bits.
// A stalled result holds; the input stage keeps accepting while the result
// register is free or being drained, so stall reaches the input only when both
// stages are full.
module word_clock_led_mask
  import wclm_pkg::*;
#(
  parameter int unsigned LedCount = NumLeds
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [HourW-1:0]    hour_of_day_i,
  input  logic [MinuteW-1:0]  minute_of_hour_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LowBits-1:0]  leds_low_o,
  output logic [HighBits-1:0] leds_high_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic                cfg_data_i
);

  wclm_cfg_t          cfg;
  logic               s1_valid_q, s1_valid_d;
  logic [HourW-1:0]   hour_q;
  logic [MinuteW-1:0] minute_q;
  logic               out_valid_q, out_valid_d;
  panel_t             panel;
  panel_t             panel_q;
  logic               out_load;
  logic               s1_load;

  wclm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  wclm_decode #(
    .LedCount (LedCount)
  ) u_decode (
    .hour_i   (hour_q),
    .minute_i (minute_q),
    .cfg_i    (cfg),
    .panel_o  (panel)
  );

  // Pipeline advance
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = s1_load ? 1'b1 : (out_load ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_load ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      hour_q   <= hour_of_day_i;
      minute_q <= minute_of_hour_i;
    end
    if (out_load && s1_valid_q) begin
      panel_q <= panel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign leds_low_o  = panel_q[LowBits-1:0];
  assign leds_high_o = panel_q[PanelBits-1:LowBits];

endmodule

// ===== design/wclm_cfg_regs.sv =====
// Configuration register file for the word clock LED mask block.
module wclm_cfg_regs
  import wclm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_data_i,
  output logic               cfg_ready_o,
  output wclm_cfg_t          cfg_o
);

  wclm_cfg_t cfg_q, cfg_d;

  // Always ready; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSouthernDialect: cfg_d.southern_dialect   = cfg_data_i;
        CfgCompactDots:     cfg_d.compact_dot_layout = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/wclm_decode.sv =====
// Time-to-mask decode: minute phrase, corner dots and hour word.
module wclm_decode
  import wclm_pkg::*;
#(
  parameter int unsigned LedCount = NumLeds
) (
  input  logic [HourW-1:0]   hour_i,
  input  logic [MinuteW-1:0] minute_i,
  input  wclm_cfg_t          cfg_i,
  output panel_t             panel_o
);

  logic [Div5ProdW-1:0] prod;
  logic [StepW-1:0]     step;
  logic [MinuteW-1:0]   step_min;
  logic [RestW-1:0]     rest;
  logic                 next_hour;
  logic [ShownW-1:0]    shown_raw;
  logic [ShownW-1:0]    shown;
  span_t                hw;
  panel_t               phrase;
  panel_t               dots;
  panel_t               hour_m;
  panel_t               usable;

  // Split minute into five-minute step and remainder
  assign prod     = Div5ProdW'(minute_i) * Div5ProdW'(Div5Mul);
  assign step     = StepW'(prod >> Div5Shift);
  assign step_min = MinuteW'({step, 2'b00}) + MinuteW'(step);
  assign rest     = RestW'(minute_i - step_min);

  // Minute phrase and next-hour flag
  always_comb begin
    phrase    = span_mask(7'd0, 7'd1) | span_mask(7'd3, 7'd5);  // ES IST
    next_hour = 1'b0;
    case (step)
      StepOclock:     phrase |= span_mask(7'd99, 7'd101);
      StepFivePast:   phrase |= span_mask(7'd7, 7'd10) | span_mask(7'd38, 7'd41);
      StepTenPast:    phrase |= span_mask(7'd18, 7'd21) | span_mask(7'd38, 7'd41);
      StepQuarter: begin
        phrase |= span_mask(7'd26, 7'd32);
        if (cfg_i.southern_dialect) next_hour = 1'b1;
        else phrase |= span_mask(7'd38, 7'd41);
      end
      StepTwentyPast: phrase |= span_mask(7'd11, 7'd17) | span_mask(7'd38, 7'd41);
      StepFiveToHalf: begin
        phrase |= span_mask(7'd7, 7'd10) | span_mask(7'd35, 7'd37)
                | span_mask(7'd44, 7'd47);
        next_hour = 1'b1;
      end
      StepHalf: begin
        phrase |= span_mask(7'd44, 7'd47);
        next_hour = 1'b1;
      end
      StepFiveAfHalf: begin
        phrase |= span_mask(7'd7, 7'd10) | span_mask(7'd38, 7'd41)
                | span_mask(7'd44, 7'd47);
        next_hour = 1'b1;
      end
      StepTwentyTo: begin
        phrase |= span_mask(7'd11, 7'd17) | span_mask(7'd35, 7'd37);
        next_hour = 1'b1;
      end
      StepQuarterTo: begin
        if (cfg_i.southern_dialect) phrase |= span_mask(7'd22, 7'd32);
        else phrase |= span_mask(7'd26, 7'd32) | span_mask(7'd35, 7'd37);
        next_hour = 1'b1;
      end
      StepTenTo: begin
        phrase |= span_mask(7'd18, 7'd21) | span_mask(7'd35, 7'd37);
        next_hour = 1'b1;
      end
      StepFiveTo: begin
        phrase |= span_mask(7'd7, 7'd10) | span_mask(7'd35, 7'd37);
        next_hour = 1'b1;
      end
      default: ;  // minute 60-63: no phrase
    endcase
  end

  // Corner dots for remainder 1-4
  always_comb begin
    dots = '0;
    if (rest >= 3'd1 && rest <= 3'd4) begin
      if (cfg_i.compact_dot_layout) begin
        dots = span_mask(7'd112, 7'd111 + LedIdxW'(rest));
      end else begin
        dots = span_mask(7'd114 - LedIdxW'(rest), 7'd113);
      end
    end
  end

  // Hour word, folded to a half day
  assign shown_raw = ShownW'(hour_i) + ShownW'(next_hour);
  assign shown     = (shown_raw >= ShownW'(HalfDay)) ? shown_raw - ShownW'(HalfDay)
                                                     : shown_raw;
  assign hw        = hour_word(shown[3:0]);

  always_comb begin
    hour_m = '0;
    if (shown == ShownW'(1) && step == StepOclock) begin
      hour_m = span_mask(7'd61, 7'd63);  // EIN
    end else if (shown <= ShownW'(HalfDay)) begin
      hour_m = span_mask(hw.lo, hw.hi);
    end
  end

  // LEDs fitted on the panel; anything at or past LedCount stays dark
  always_comb begin
    usable = '0;
    for (int p = 0; p < PanelBits; p++) begin
      if (p < LedCount) usable[p] = 1'b1;
    end
  end

  assign panel_o = (phrase | dots | hour_m) & usable;

endmodule
